FILE: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define GTP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtp assertion failed");

// next-cycle implication, checked outside reset
`define GTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtp assertion failed");

`endif

FILE: sv/gtp_pkg.sv
// types and constants of the guid text parser
`default_nettype none

package gtp_pkg;

    localparam logic [7:0] DASH_CHAR = 8'h2D;
    localparam logic [5:0] LAST_POS  = 6'd35;
    localparam logic [5:0] SPLIT_POS = 6'd19;
    localparam logic [5:0] DASH_POS0 = 6'd8;
    localparam logic [5:0] DASH_POS1 = 6'd13;
    localparam logic [5:0] DASH_POS2 = 6'd18;
    localparam logic [5:0] DASH_POS3 = 6'd23;

    // classified character handed from front to back
    typedef struct packed {
        logic       first;
        logic       is_dash;
        logic       is_hex;
        logic [3:0] nibble;
    } t_char_class;

    // one parse result
    typedef struct packed {
        logic [5:0]  fail_position;
        logic        parse_ok;
        logic [47:0] node_id;
        logic [15:0] clock_sequence;
        logic [15:0] time_hi_version;
        logic [15:0] group_mid;
        logic [31:0] group_low;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/gtp_front.sv
// input side: accepts characters and classifies them
`default_nettype none

module gtp_front (
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,
    input  wire logic [0:0]          s_axis_tuser,
    input  wire logic                i_q_full,
    output logic                     o_push,
    output gtp_pkg::t_char_class     o_cls
);
    import gtp_pkg::*;

    logic [7:0] w_c;

    assign w_c           = s_axis_tdata;
    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    always_comb begin
        o_cls.first   = s_axis_tuser[0];
        o_cls.is_dash = (w_c == DASH_CHAR);
        o_cls.is_hex  = 1'b0;
        o_cls.nibble  = 4'd0;
        if (w_c >= 8'h30 && w_c <= 8'h39) begin
            o_cls.is_hex = 1'b1;
            o_cls.nibble = w_c[3:0];
        end else if ((w_c >= 8'h41 && w_c <= 8'h46) || (w_c >= 8'h61 && w_c <= 8'h66)) begin
            // letters a-f: low three bits 1..6 map to 10..15
            o_cls.is_hex = 1'b1;
            o_cls.nibble = 4'd9 + {1'b0, w_c[2:0]};
        end
    end

endmodule

`default_nettype wire

FILE: sv/gtp_queue.sv
// short fifo between the classifier and the assembler
`default_nettype none

module gtp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire gtp_pkg::t_char_class i_wdata,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_valid,
    output gtp_pkg::t_char_class     o_rdata
);
    import gtp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_char_class   r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

FILE: sv/gtp_back.sv
// assembler: tracks position, shifts in digits, holds the result register
`default_nettype none

module gtp_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_entry_valid,
    input  wire gtp_pkg::t_char_class i_cls,
    output logic                      o_pop,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output gtp_pkg::t_result          o_result
);
    import gtp_pkg::*;

    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_a0, n_a0;
    logic [63:0] r_a1, n_a1;
    logic        r_fin, n_fin;
    logic        r_out_valid;
    t_result     r_result, n_result;

    logic [5:0]  w_pos;
    logic [63:0] w_a0, w_a1;
    logic        w_fin, w_dash_slot, w_good, w_shift, w_emit;

    assign o_pop       = i_entry_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        // a first character restarts the text
        w_pos = i_cls.first ? 6'd0  : r_pos;
        w_fin = i_cls.first ? 1'b0  : r_fin;
        w_a0  = i_cls.first ? 64'd0 : r_a0;
        w_a1  = i_cls.first ? 64'd0 : r_a1;

        w_dash_slot = (w_pos == DASH_POS0) || (w_pos == DASH_POS1) ||
                      (w_pos == DASH_POS2) || (w_pos == DASH_POS3);
        w_good  = w_dash_slot ? i_cls.is_dash : i_cls.is_hex;
        w_shift = !w_fin && !w_dash_slot && i_cls.is_hex;
        w_emit  = !w_fin && (!w_good || (w_pos >= LAST_POS));

        n_a0 = w_a0;
        n_a1 = w_a1;
        if (w_shift && (w_pos < SPLIT_POS)) begin
            n_a0 = {w_a0[59:0], i_cls.nibble};
        end
        if (w_shift && (w_pos >= SPLIT_POS)) begin
            n_a1 = {w_a1[59:0], i_cls.nibble};
        end
        n_fin = w_fin || w_emit;
        n_pos = (w_fin || w_emit) ? w_pos : w_pos + 6'd1;

        n_result = '0;
        n_result.fail_position = w_pos;
        if (w_good) begin
            n_result.group_low       = n_a0[63:32];
            n_result.group_mid       = n_a0[31:16];
            n_result.time_hi_version = n_a0[15:0];
            n_result.clock_sequence  = n_a1[63:48];
            n_result.node_id         = n_a1[47:0];
            n_result.parse_ok        = 1'b1;
            n_result.fail_position   = LAST_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_a0        <= '0;
            r_a1        <= '0;
            r_fin       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos <= n_pos;
                r_a0  <= n_a0;
                r_a1  <= n_a1;
                r_fin <= n_fin;
            end
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

FILE: sv/guid_text_parser.sv
// top level of the guid text parser: classifier, queue and assembler
//
//  channel   | dir | tdata                         | tuser
//  s_axis    | in  | text_char[7:0]                | first[0]
//  m_axis    | out | five guid groups, fail pos    | parse_ok[0]
//
// one character per cycle until the queue is full; one queued item retired per cycle
// unless m_axis stalls a held result; the queue sits before the result register
// reset clears queue pointers, position and result valid; parser waits for a first item
// a stalled m_axis holds the result register; the queue (QUEUE_DEPTH items) keeps taking input
// s_axis_tready drops only when the queue is full
`default_nettype none
`include "assert_macros.svh"

module guid_text_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input characters
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // text_char[7:0]
    input  wire logic [0:0]    s_axis_tuser,   // first[0]
    // parse results
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [135:0]       m_axis_tdata,   // group_low[31:0], group_mid[47:32],
                                               // time_hi_version[63:48],
                                               // clock_sequence[79:64], node_id[127:80],
                                               // fail_position[133:128], zero[135:134]
    output logic [0:0]         m_axis_tuser    // parse_ok[0]
);
    import gtp_pkg::*;

    t_char_class w_cls_in;
    t_char_class w_cls_out;
    t_result     w_result;
    logic        w_push;
    logic        w_full;
    logic        w_q_valid;
    logic        w_pop;

    // front: handshake and character decode
    gtp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_cls         (w_cls_in)
    );

    // decoupling queue so either side can stall alone
    gtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_cls_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_rdata (w_cls_out)
    );

    // back: position tracking, digit assembly, result register
    gtp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (w_q_valid),
        .i_cls         (w_cls_out),
        .o_pop         (w_pop),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_result      (w_result)
    );

    // pack result fields, highest first
    assign m_axis_tdata = {2'b00,
                           w_result.fail_position,
                           w_result.node_id,
                           w_result.clock_sequence,
                           w_result.time_hi_version,
                           w_result.group_mid,
                           w_result.group_low};
    assign m_axis_tuser[0] = w_result.parse_ok;

    // a good result always reports the last position
    `GTP_ASSERT_IMPLY(a_ok_pos, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[133:128] == LAST_POS)
    // a failed result carries zero groups
    `GTP_ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[127:0] == 128'd0)
    // a failure never points past the text
    `GTP_ASSERT_IMPLY(a_fail_range, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[133:128] < LAST_POS + 6'd1)
    // an untaken result stays put
    `GTP_ASSERT_NEXT(a_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

`default_nettype wire

FILE: tb/guid_text_parser_tb.sv
// testbench of guid_text_parser: directed and random guid texts checked against a predictor
`timescale 1ns / 1ps
`default_nettype none

module guid_text_parser_tb;
    import gtp_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int TARGET_CHARS = 950;
    localparam int DRAIN_CYCLES = 20;

    // bytes just outside the hex digit ranges: '\0' '/' ':' '@' 'G' '`' 'g' 0xff
    localparam logic [7:0] NEAR_HEX [8] = '{8'h00, 8'h2F, 8'h3A, 8'h40,
                                            8'h47, 8'h60, 8'h67, 8'hFF};

    // predicts the parse result of each text and checks the results in order
    class guid_parse_checker;
        bit [5:0]  char_pos;
        bit [63:0] groups_head;   // group_low:group_mid:time_hi_version
        bit [63:0] groups_tail;   // clock_sequence:node_id
        bit        done = 1'b1;   // waiting for a first item
        int        errors;
        t_result   expected_guids[$];

        // returns 1 when the character is parsed, 0 when it is ignored
        function bit take_char(logic [7:0] c, logic first_flag);
            logic [4:0] nib;
            logic       ok;
            t_result    want;
            if (first_flag) begin
                char_pos    = '0;
                groups_head = '0;
                groups_tail = '0;
                done        = 1'b0;
            end
            if (done)
                return 1'b0;
            if (char_pos == DASH_POS0 || char_pos == DASH_POS1 ||
                char_pos == DASH_POS2 || char_pos == DASH_POS3) begin
                ok = (c == DASH_CHAR);
            end else begin
                // '0'-'9', then 'A'-'F' and 'a'-'f' share their low nibble
                if (c >= 8'h30 && c <= 8'h39)
                    nib = {1'b0, c[3:0]};
                else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                    nib = {1'b0, c[3:0] + 4'd9};
                else
                    nib = 5'h10;
                ok = !nib[4];
                if (ok && char_pos < SPLIT_POS)
                    groups_head = {groups_head[59:0], nib[3:0]};
                else if (ok)
                    groups_tail = {groups_tail[59:0], nib[3:0]};
            end
            want = '0;
            if (!ok) begin
                want.fail_position = char_pos;
                expected_guids.push_back(want);
                done = 1'b1;
            end else if (char_pos >= LAST_POS) begin
                want.group_low       = groups_head[63:32];
                want.group_mid       = groups_head[31:16];
                want.time_hi_version = groups_head[15:0];
                want.clock_sequence  = groups_tail[63:48];
                want.node_id         = groups_tail[47:0];
                want.parse_ok        = 1'b1;
                want.fail_position   = LAST_POS;
                expected_guids.push_back(want);
                done = 1'b1;
            end else begin
                char_pos = char_pos + 6'd1;
            end
            return 1'b1;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [135:0] data, logic [0:0] user);
            t_result got;
            t_result want;
            got                 = '0;
            got.group_low       = data[31:0];
            got.group_mid       = data[47:32];
            got.time_hi_version = data[63:48];
            got.clock_sequence  = data[79:64];
            got.node_id         = data[127:80];
            got.fail_position   = data[133:128];
            got.parse_ok        = user[0];
            if (expected_guids.size() == 0) begin
                report("result with no text pending", 64'(got.group_low), '0);
                return;
            end
            want = expected_guids.pop_front();
            if (got.group_low != want.group_low)
                report("group_low", 64'(got.group_low), 64'(want.group_low));
            if (got.group_mid != want.group_mid)
                report("group_mid", 64'(got.group_mid), 64'(want.group_mid));
            if (got.time_hi_version != want.time_hi_version)
                report("time_hi_version", 64'(got.time_hi_version),
                       64'(want.time_hi_version));
            if (got.clock_sequence != want.clock_sequence)
                report("clock_sequence", 64'(got.clock_sequence),
                       64'(want.clock_sequence));
            if (got.node_id != want.node_id)
                report("node_id", 64'(got.node_id), 64'(want.node_id));
            if (got.parse_ok != want.parse_ok)
                report("parse_ok", 64'(got.parse_ok), 64'(want.parse_ok));
            if (got.fail_position != want.fail_position)
                report("fail_position", 64'(got.fail_position), 64'(want.fail_position));
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [7:0]   s_char = '0;
    logic         s_first = 1'b0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [135:0] m_data;
    logic [0:0]   m_user;

    guid_parse_checker model = new();
    int  cycles;
    int  parsed_chars;
    int  stall_left;
    bit  calm;            // no idling on either side while set

    always #4 i_clk = ~i_clk;

    guid_text_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_char),     // text_char[7:0]
        .s_axis_tuser  (s_first),    // first[0]
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),     // group_low, group_mid, time_hi_version,
                                     // clock_sequence, node_id, fail_position
        .m_axis_tuser  (m_user)      // parse_ok[0]
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random hex digit, either case for letters
    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'(8'h30 + v);
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    // well-formed character for a text position
    function automatic logic [7:0] guid_char_at(int p);
        if (p == DASH_POS0 || p == DASH_POS1 || p == DASH_POS2 || p == DASH_POS3)
            return DASH_CHAR;
        return rand_hex_char();
    endfunction

    // one item on the character side; valid stays up when the next item follows at once
    task automatic push(input logic [7:0] c, input logic first_flag);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_valid = 1'b0;
        end
        @(negedge i_clk);
        s_valid = 1'b1;
        s_char  = c;
        s_first = first_flag;
        do @(posedge i_clk); while (!s_ready);
        if (model.take_char(c, first_flag))
            parsed_chars++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push(s[i], i == 0);
    endtask

    task automatic hold_sender();
        @(negedge i_clk);
        s_valid = 1'b0;
    endtask

    task automatic wait_all_results();
        while (model.expected_guids.size() != 0)
            @(posedge i_clk);
    endtask

    // result side: random stalls applied at the falling edge
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            m_ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            model.check_result(m_data, m_user);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("guid_text_parser_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int kind;
        int stop_at;
        logic [7:0] c;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // characters before any first item are dropped
        push(8'h30, 1'b0);
        push(8'hFF, 1'b0);
        // valid texts: mixed digits, all ones, all zeros
        push_text("01234567-89ab-CDEF-0123-456789aBcDeF");
        push_text("FFFFFFFF-ffff-FFFF-ffff-FFFFFFFFFFFF");
        push_text("00000000-0000-0000-0000-000000000000");
        // characters past the last position, then after a result, are dropped
        push(8'h61, 1'b0);
        push(DASH_CHAR, 1'b0);
        // bad first character: terminating nul and every byte around the digit ranges
        foreach (NEAR_HEX[i])
            push(NEAR_HEX[i], 1'b1);
        push(DASH_CHAR, 1'b1);
        // hex digit where a dash belongs
        push_text("ABCDEF019");
        // new first in mid-text abandons the old one
        push_text("12ab");
        push_text("9");

        hold_sender();
        wait_all_results();
        for (int t = 0; parsed_chars < TARGET_CHARS; t++) begin
            calm = (t >= 30 && t < 45);
            if (t == 15) begin
                // hold off until the block has returned every pending result
                hold_sender();
                wait_all_results();
            end
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                // well-formed text, below 55 complete, else broken at a random position
                stop_at = (kind < 55) ? 36 : $urandom_range(0, 35);
                for (int i = 0; i < stop_at; i++)
                    push(guid_char_at(i), i == 0);
                if (stop_at < 36) begin
                    case ($urandom_range(0, 3))
                        0: c = NEAR_HEX[$urandom_range(0, 7)];
                        1: c = (guid_char_at(stop_at) == DASH_CHAR) ?
                               rand_hex_char() : DASH_CHAR;
                        default: c = 8'($urandom_range(0, 255));
                    endcase
                    push(c, stop_at == 0);
                end
                repeat ($urandom_range(0, 2))
                    push(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 90) begin
                // prefix only, abandoned by the next first item
                stop_at = $urandom_range(1, 35);
                for (int i = 0; i < stop_at; i++)
                    push(guid_char_at(i), i == 0);
            end else begin
                // raw noise bytes, first flag random
                repeat ($urandom_range(1, 3))
                    push(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
        calm = 1'b0;

        hold_sender();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (model.errors == 0)
            $display("guid_text_parser_tb: PASS");
        else
            $display("guid_text_parser_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: guid_text_parser.f
+incdir+sv
sv/gtp_pkg.sv
sv/gtp_front.sv
sv/gtp_queue.sv
sv/gtp_back.sv
sv/guid_text_parser.sv
tb/guid_text_parser_tb.sv
